// ----- design/chisq_pkg.sv -----
// Package with shared types, constants and helper functions for the chi-square test unit.
package chisq_pkg;

  localparam int VALUE_W            = 8;
  localparam int SAMPLE_W           = 16;
  localparam int VERDICT_W          = 3;
  localparam int STAT_W             = 28;
  localparam int NUM_BINS           = 10;
  localparam int BIN_IDX_W          = 4;
  localparam int DEFAULT_COUNT_BITS = 16;

  localparam logic [VALUE_W-1:0]  MAX_VALUE            = 8'd99;
  localparam logic [SAMPLE_W-1:0] RESET_SAMPLE_COUNT   = 16'd100;
  localparam logic [SAMPLE_W-1:0] LIMIT_SUSPICIOUS     = 16'd14684;
  localparam logic [SAMPLE_W-1:0] LIMIT_UNLIKELY       = 16'd21666;
  localparam logic [BIN_IDX_W-1:0] LAST_BIN            = 4'd9;

  localparam logic [VERDICT_W-1:0] VERDICT_CONSISTENT  = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_SUSPICIOUS  = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_UNLIKELY    = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_RANGE_ERROR = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_TOO_FEW     = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_NSQ,
    ST_DIFF,
    ST_LIM1,
    ST_CMP1,
    ST_LIM2,
    ST_CMP2,
    ST_DIV,
    ST_DONE
  } state_t;

  // Bin number of a value in 0..99, which is the value divided by ten.
  function automatic logic [BIN_IDX_W-1:0] bin_index(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

endpackage

// ----- design/chi_square_uniformity_test_unit.sv -----
// Top level of the chi-square uniformity test over ten bins.
//
// Values are binned at one transfer per clock cycle while in_ready is high. The transfer that
// completes a sequence of sample_count values starts an evaluation on one shared multiplier
// and a restoring divider: the ten bins are squared and summed in turn, the difference and the
// two limit compares are formed, and the divider produces one quotient bit per cycle. in_ready
// stays low after the completing transfer until the result is loaded into the output register.
// Error verdicts appear in the cycle after the transfer that causes them. A result is held in
// an output register until it is taken, and no new transfer is accepted while it waits.
module chi_square_uniformity_test_unit #(
  parameter int COUNT_BITS = chisq_pkg::DEFAULT_COUNT_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [chisq_pkg::VALUE_W-1:0]      value,
  input  logic                               last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [chisq_pkg::VERDICT_W-1:0]    verdict,
  output logic [chisq_pkg::STAT_W-1:0]       statistic_q8,
  input  logic                               cfg_write,
  input  logic [chisq_pkg::SAMPLE_W-1:0]     cfg_data
);

  localparam int SB  = (COUNT_BITS < 17) ? COUNT_BITS : 17;
  localparam int MW  = (SB > 16) ? SB : 16;
  localparam int PW  = 2 * MW;
  localparam int SW  = 2 * SB + 4;
  localparam int DW  = (2 * SB + 8 > 33) ? 2 * SB + 8 : 33;
  localparam int CW  = DW + 10;
  localparam int QW  = DW + 8;
  localparam int DCW = $clog2(QW + 1);
  localparam int RW  = chisq_pkg::SAMPLE_W + 1;

  chisq_pkg::state_t state, state_next;

  logic [COUNT_BITS-1:0]             bin_counts [chisq_pkg::NUM_BINS];
  logic [chisq_pkg::SAMPLE_W-1:0]    values_seen;
  logic                              discarding;
  logic [chisq_pkg::SAMPLE_W-1:0]    sample_count;
  logic [chisq_pkg::BIN_IDX_W-1:0]   idx;
  logic [PW-1:0]                     prod;
  logic [SW-1:0]                     sum_sq;
  logic [DW-1:0]                     diff;
  logic                              le1;
  logic [chisq_pkg::VERDICT_W-1:0]   verdict_r;
  logic [QW-1:0]                     quo;
  logic [RW-1:0]                     rem;
  logic [DCW-1:0]                    div_cnt;

  logic [chisq_pkg::SAMPLE_W-1:0]    n_eff;
  logic [chisq_pkg::SAMPLE_W-1:0]    vs_next;
  logic                              in_xfer;
  logic                              out_free;
  logic                              in_range;
  logic                              complete_hit;
  logic [chisq_pkg::BIN_IDX_W-1:0]   in_bin;
  logic [MW-1:0]                     mul_a;
  logic [MW-1:0]                     mul_b;
  logic [DW-1:0]                     ten_s;
  logic [CW-1:0]                     lhs;
  logic [RW-1:0]                     shifted;
  logic                              fits;

  assign n_eff        = (sample_count == '0) ? chisq_pkg::SAMPLE_W'(1) : sample_count;
  assign vs_next      = values_seen + chisq_pkg::SAMPLE_W'(1);
  assign out_free     = !out_valid || out_ready;
  assign in_xfer      = in_valid && in_ready;
  assign in_range     = (value <= chisq_pkg::MAX_VALUE);
  assign complete_hit = !discarding && in_range && (vs_next == n_eff);
  assign in_bin       = chisq_pkg::bin_index(value[6:0]);

  assign ten_s   = DW'({sum_sq, 3'b000}) + DW'({sum_sq, 1'b0});
  assign lhs     = CW'({diff, 10'b0}) - CW'({diff, 4'b0}) - CW'({diff, 3'b0});
  assign shifted = {rem[RW-2:0], quo[QW-1]};
  assign fits    = (shifted >= RW'(n_eff));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      chisq_pkg::ST_SQUARE: begin
        mul_a = MW'(bin_counts[idx][SB-1:0]);
        mul_b = MW'(bin_counts[idx][SB-1:0]);
      end
      chisq_pkg::ST_NSQ: begin
        mul_a = MW'(n_eff);
        mul_b = MW'(n_eff);
      end
      chisq_pkg::ST_LIM1: begin
        mul_a = MW'(chisq_pkg::LIMIT_SUSPICIOUS);
        mul_b = MW'(n_eff);
      end
      chisq_pkg::ST_LIM2: begin
        mul_a = MW'(chisq_pkg::LIMIT_UNLIKELY);
        mul_b = MW'(n_eff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      chisq_pkg::ST_IDLE: begin
        if (in_xfer && complete_hit) begin
          state_next = chisq_pkg::ST_SQUARE;
        end
      end
      chisq_pkg::ST_SQUARE: state_next = chisq_pkg::ST_ACCUM;
      chisq_pkg::ST_ACCUM: begin
        if (idx == chisq_pkg::LAST_BIN) begin
          state_next = chisq_pkg::ST_NSQ;
        end else begin
          state_next = chisq_pkg::ST_SQUARE;
        end
      end
      chisq_pkg::ST_NSQ:  state_next = chisq_pkg::ST_DIFF;
      chisq_pkg::ST_DIFF: state_next = chisq_pkg::ST_LIM1;
      chisq_pkg::ST_LIM1: state_next = chisq_pkg::ST_CMP1;
      chisq_pkg::ST_CMP1: state_next = chisq_pkg::ST_LIM2;
      chisq_pkg::ST_LIM2: state_next = chisq_pkg::ST_CMP2;
      chisq_pkg::ST_CMP2: state_next = chisq_pkg::ST_DIV;
      chisq_pkg::ST_DIV: begin
        if (div_cnt == DCW'(QW - 1)) begin
          state_next = chisq_pkg::ST_DONE;
        end
      end
      chisq_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = chisq_pkg::ST_IDLE;
        end
      end
      default: state_next = chisq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == chisq_pkg::ST_IDLE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= chisq_pkg::ST_IDLE;
      values_seen  <= '0;
      discarding   <= 1'b0;
      sample_count <= chisq_pkg::RESET_SAMPLE_COUNT;
      out_valid    <= 1'b0;
      idx          <= '0;
      div_cnt      <= '0;
      for (int i = 0; i < chisq_pkg::NUM_BINS; i++) begin
        bin_counts[i] <= '0;
      end
    end else begin
      state <= state_next;

      if (cfg_write) begin
        sample_count <= cfg_data;
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        chisq_pkg::ST_IDLE: begin
          if (in_xfer) begin
            if (discarding) begin
              if (last) begin
                discarding <= 1'b0;
              end
            end else if (!in_range) begin
              for (int i = 0; i < chisq_pkg::NUM_BINS; i++) begin
                bin_counts[i] <= '0;
              end
              values_seen  <= '0;
              discarding   <= !last;
              verdict      <= chisq_pkg::VERDICT_RANGE_ERROR;
              statistic_q8 <= '0;
              out_valid    <= 1'b1;
            end else begin
              if ((bin_counts[in_bin] != '1) && (complete_hit || !last)) begin
                bin_counts[in_bin] <= bin_counts[in_bin] + COUNT_BITS'(1);
              end
              if (complete_hit) begin
                values_seen <= '0;
                discarding  <= !last;
                idx         <= '0;
                sum_sq      <= '0;
              end else if (last) begin
                for (int i = 0; i < chisq_pkg::NUM_BINS; i++) begin
                  bin_counts[i] <= '0;
                end
                values_seen  <= '0;
                verdict      <= chisq_pkg::VERDICT_TOO_FEW;
                statistic_q8 <= '0;
                out_valid    <= 1'b1;
              end else begin
                values_seen <= vs_next;
              end
            end
          end
        end
        chisq_pkg::ST_SQUARE: begin
          prod <= mul_a * mul_b;
        end
        chisq_pkg::ST_ACCUM: begin
          sum_sq <= sum_sq + SW'(prod[2*SB-1:0]);
          idx    <= idx + chisq_pkg::BIN_IDX_W'(1);
          if (idx == chisq_pkg::LAST_BIN) begin
            for (int i = 0; i < chisq_pkg::NUM_BINS; i++) begin
              bin_counts[i] <= '0;
            end
          end
        end
        chisq_pkg::ST_NSQ: begin
          prod <= mul_a * mul_b;
        end
        chisq_pkg::ST_DIFF: begin
          if (ten_s > DW'(prod)) begin
            diff <= ten_s - DW'(prod);
          end else begin
            diff <= '0;
          end
        end
        chisq_pkg::ST_LIM1: begin
          prod <= mul_a * mul_b;
        end
        chisq_pkg::ST_CMP1: begin
          le1 <= (lhs <= CW'(prod));
        end
        chisq_pkg::ST_LIM2: begin
          prod <= mul_a * mul_b;
        end
        chisq_pkg::ST_CMP2: begin
          if (le1) begin
            verdict_r <= chisq_pkg::VERDICT_CONSISTENT;
          end else if (lhs <= CW'(prod)) begin
            verdict_r <= chisq_pkg::VERDICT_SUSPICIOUS;
          end else begin
            verdict_r <= chisq_pkg::VERDICT_UNLIKELY;
          end
          quo     <= {diff, 8'b0};
          rem     <= '0;
          div_cnt <= '0;
        end
        chisq_pkg::ST_DIV: begin
          if (fits) begin
            rem <= shifted - RW'(n_eff);
          end else begin
            rem <= shifted;
          end
          quo     <= {quo[QW-2:0], fits};
          div_cnt <= div_cnt + DCW'(1);
        end
        chisq_pkg::ST_DONE: begin
          if (out_free) begin
            verdict      <= verdict_r;
            statistic_q8 <= quo[chisq_pkg::STAT_W-1:0];
            out_valid    <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the chi-square uniformity test unit.
module testbench;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_ITEMS = 350;

  typedef struct packed {
    logic [chisq_pkg::VERDICT_W-1:0] verdict;
    logic [chisq_pkg::STAT_W-1:0]    stat;
  } verdict_rec_t;

  typedef enum int {
    SPREAD_EVEN,
    SPREAD_ONE_BIN,
    SPREAD_TWO_BINS,
    SPREAD_HOT_ONLY
  } spread_t;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [chisq_pkg::VALUE_W-1:0]   value = '0;
  logic                            last = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [chisq_pkg::VERDICT_W-1:0] verdict;
  logic [chisq_pkg::STAT_W-1:0]    statistic_q8;
  logic                            cfg_write = 1'b0;
  logic [chisq_pkg::SAMPLE_W-1:0]  cfg_data = '0;

  logic [chisq_pkg::DEFAULT_COUNT_BITS-1:0] bin_tally [chisq_pkg::NUM_BINS];
  logic [chisq_pkg::SAMPLE_W-1:0]           seen_count;
  logic                                     skipping;
  logic [chisq_pkg::SAMPLE_W-1:0]           seq_len;
  verdict_rec_t                             pending_verdicts [$];
  int                                       mismatch_count = 0;
  int                                       items_binned = 0;
  int                                       stuck_cycles = 0;
  int                                       stall_left = 0;
  bit                                       idle_on = 1'b1;

  chi_square_uniformity_test_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .value        (value),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .verdict      (verdict),
    .statistic_q8 (statistic_q8),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic clear_tally();
    foreach (bin_tally[k]) bin_tally[k] = '0;
    seen_count = '0;
  endtask

  task automatic predict_verdict(input logic [chisq_pkg::VALUE_W-1:0] v, input logic l);
    longint unsigned n;
    longint unsigned sq_sum;
    longint unsigned diff;
    longint unsigned b;
    verdict_rec_t    rec;
    int              k;
    n = (seq_len == 0) ? 1 : seq_len;
    if (skipping) begin
      if (l) skipping = 1'b0;
      return;
    end
    items_binned++;
    if (v > chisq_pkg::MAX_VALUE) begin
      clear_tally();
      skipping = !l;
      rec.verdict = chisq_pkg::VERDICT_RANGE_ERROR;
      rec.stat = '0;
      pending_verdicts.push_back(rec);
      return;
    end
    k = v / 10;
    if (bin_tally[k] != '1) bin_tally[k]++;
    seen_count++;
    if (seen_count == n) begin
      sq_sum = 0;
      foreach (bin_tally[i]) begin
        b = bin_tally[i];
        sq_sum += b * b;
      end
      diff = (10 * sq_sum > n * n) ? 10 * sq_sum - n * n : 0;
      if (1000 * diff <= chisq_pkg::LIMIT_SUSPICIOUS * n) begin
        rec.verdict = chisq_pkg::VERDICT_CONSISTENT;
      end else if (1000 * diff <= chisq_pkg::LIMIT_UNLIKELY * n) begin
        rec.verdict = chisq_pkg::VERDICT_SUSPICIOUS;
      end else begin
        rec.verdict = chisq_pkg::VERDICT_UNLIKELY;
      end
      rec.stat = chisq_pkg::STAT_W'((diff * 256) / n);
      clear_tally();
      skipping = !l;
      pending_verdicts.push_back(rec);
    end else if (l) begin
      clear_tally();
      rec.verdict = chisq_pkg::VERDICT_TOO_FEW;
      rec.stat = '0;
      pending_verdicts.push_back(rec);
    end
  endtask

  always @(posedge clk) begin : monitor
    verdict_rec_t want;
    if (rst) begin
      clear_tally();
      skipping = 1'b0;
      seq_len = chisq_pkg::RESET_SAMPLE_COUNT;
      stuck_cycles = 0;
    end else begin
      if (cfg_write) seq_len = cfg_data;
      if (in_valid && in_ready) predict_verdict(value, last);
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch($sformatf("unexpected result, verdict %0d statistic %0d",
                                    verdict, statistic_q8));
        end else begin
          want = pending_verdicts.pop_front();
          if (verdict !== want.verdict)
            report_mismatch($sformatf("verdict %0d, expected %0d", verdict, want.verdict));
          if (statistic_q8 !== want.stat)
            report_mismatch($sformatf("statistic %0d, expected %0d", statistic_q8, want.stat));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(input logic [chisq_pkg::VALUE_W-1:0] v, input logic l);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    last <= l;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_sample_count(input logic [chisq_pkg::SAMPLE_W-1:0] n);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data <= n;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [chisq_pkg::VALUE_W-1:0] pick_value(input spread_t spread,
                                                               input int hot_bin);
    int b;
    case (spread)
      SPREAD_ONE_BIN:  b = ($urandom_range(0, 9) < 7) ? hot_bin : $urandom_range(0, 9);
      SPREAD_TWO_BINS: b = ($urandom_range(0, 1) == 0) ? hot_bin : (hot_bin + 5) % 10;
      SPREAD_HOT_ONLY: b = hot_bin;
      default:         b = $urandom_range(0, 9);
    endcase
    return chisq_pkg::VALUE_W'(b * 10 + $urandom_range(0, 9));
  endfunction

  task automatic send_run(input int count, input spread_t spread, input int hot_bin,
                          input logic end_mark);
    for (int i = 1; i <= count; i++) send_item(pick_value(spread, hot_bin), end_mark && i == count);
  endtask

  task automatic test_default_length();
    for (int i = 0; i < 100; i++) send_item(chisq_pkg::VALUE_W'(i), i == 99);
  endtask

  task automatic test_directed();
    logic [chisq_pkg::VALUE_W-1:0] skewed [10] = '{0, 1, 2, 3, 10, 11, 12, 20, 30, 40};
    set_sample_count(16'd1);
    send_item(8'd0, 1'b1);
    send_item(8'd99, 1'b0);
    send_item(8'd50, 1'b0);
    send_item(8'd255, 1'b1);
    send_item(8'd100, 1'b1);
    send_item(8'd255, 1'b0);
    send_item(8'd3, 1'b1);
    set_sample_count(16'd0);
    send_item(8'd7, 1'b1);
    set_sample_count(16'd10);
    send_item(8'd5, 1'b1);
    foreach (skewed[i]) send_item(skewed[i], i == 9);
  endtask

  task automatic test_random_traffic(input int target);
    int      n;
    int      m;
    int      hot;
    spread_t spread;
    logic    l;
    while (items_binned < target) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 16);
      set_sample_count(chisq_pkg::SAMPLE_W'(n));
      repeat ($urandom_range(4, 8)) begin
        hot = $urandom_range(0, 9);
        spread = spread_t'($urandom_range(0, 2));
        case ($urandom_range(0, 9))
          6: begin
            send_run(n, spread, hot, 1'b0);
            repeat ($urandom_range(0, 3))
              send_item(chisq_pkg::VALUE_W'($urandom_range(0, 255)), 1'b0);
            send_item(chisq_pkg::VALUE_W'($urandom_range(0, 255)), 1'b1);
          end
          7: begin
            if (n > 1) begin
              send_run($urandom_range(1, n - 1), spread, hot, 1'b1);
            end else begin
              send_run(n, spread, hot, 1'b1);
            end
          end
          8: begin
            send_run($urandom_range(0, n - 1), spread, hot, 1'b0);
            l = 1'($urandom_range(0, 1));
            send_item(chisq_pkg::VALUE_W'($urandom_range(100, 255)), l);
            if (!l) begin
              repeat ($urandom_range(0, 3))
                send_item(chisq_pkg::VALUE_W'($urandom_range(0, 255)), 1'b0);
              send_item(chisq_pkg::VALUE_W'($urandom_range(0, 255)), 1'b1);
            end
          end
          9: begin
            repeat ($urandom_range(1, 4))
              send_item(chisq_pkg::VALUE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            send_item(8'd200, 1'b1);
          end
          default: send_run(n, spread, hot, 1'b1);
        endcase
      end
    end
  endtask

  task automatic test_unstalled_traffic();
    idle_on = 1'b0;
    set_sample_count(16'd60);
    send_run(60, SPREAD_HOT_ONLY, 9, 1'b1);
    set_sample_count(16'd37);
    repeat (2) send_run(37, SPREAD_EVEN, 0, 1'b1);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_default_length();
    test_directed();
    test_random_traffic(items_binned + RANDOM_ITEMS);
    test_unstalled_traffic();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/chisq_pkg.sv
design/chi_square_uniformity_test_unit.sv
verif/testbench.sv
